// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPLIES(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, a) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(a)) \
        else $error("assertion failed");
`endif

// ===== rtl/core/ptsp_pkg.sv =====
// types and constants for the package toc stream parser
// no dependencies
package ptsp_pkg;
    localparam int unsigned DEF_MAX_ENTRIES = 32;
    localparam int unsigned SIG_LEN = 6;
    localparam logic [7:0] BRACE_CHAR = 8'h7b;
    localparam logic [7:0] NEWLINE_CHAR = 8'h0a;
    localparam logic [32:0] ALL32 = 33'h0_ffff_ffff;

    typedef enum logic [3:0] {
        ST_BUNDLE_OK = 4'd0,
        ST_SINGLE_OK = 4'd1,
        ST_SHORT     = 4'd2,
        ST_BAD_MAGIC = 4'd3,
        ST_EMPTY     = 4'd4,
        ST_NO_NL     = 4'd5,
        ST_COUNT_CUT = 4'd6,
        ST_TOO_MANY  = 4'd7,
        ST_TOC_CUT   = 4'd8,
        ST_BLOBS_CUT = 4'd9
    } status_t;

    typedef struct packed {
        logic [4:0]  entry_index;
        logic [31:0] name_offset;
        logic [7:0]  name_length;
        logic [7:0]  entry_flags;
        logic [31:0] plain_length;
        logic [31:0] stored_length;
        logic [31:0] blob_offset;
        logic [3:0]  status;
        logic [5:0]  entry_count;
        logic [31:0] payload_offset;
        logic [31:0] payload_length;
        logic        last;
    } result_t;

    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] r;
        begin
            case (idx)
                3'd0: r = 8'h50;
                3'd1: r = 8'h41;
                3'd2: r = 8'h50;
                3'd3: r = 8'h50;
                3'd4: r = 8'h31;
                3'd5: r = 8'h0a;
                default: r = 8'h50;
            endcase
            return r;
        end
    endfunction
endpackage

// ===== rtl/core/ptsp_front.sv =====
// front end: byte parser, builds record and summary items
// depends on ptsp_pkg
module ptsp_front
    import ptsp_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = DEF_MAX_ENTRIES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [7:0]  data_byte,
    input  logic        end_of_data,
    output logic        rec_valid,
    output logic        sum_valid,
    output result_t     rec_item,
    output result_t     sum_item
);
    typedef enum logic [11:0] {
        PH_MAGIC   = 12'b000000000001,
        PH_DETECT  = 12'b000000000010,
        PH_SEEK    = 12'b000000000100,
        PH_BODY    = 12'b000000001000,
        PH_COUNTHI = 12'b000000010000,
        PH_NAMELEN = 12'b000000100000,
        PH_NAME    = 12'b000001000000,
        PH_FLAGS   = 12'b000010000000,
        PH_LEN     = 12'b000100000000,
        PH_STORED  = 12'b001000000000,
        PH_BLOBS   = 12'b010000000000,
        PH_HALT    = 12'b100000000000
    } phase_t;

    phase_t phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [7:0]  fcnt_reg, fcnt_next;
    logic [15:0] decl_reg, decl_next;
    logic [5:0]  cur_reg, cur_next;
    logic [7:0]  nlen_reg, nlen_next;
    logic [31:0] noff_reg, noff_next;
    logic [7:0]  flags_reg, flags_next;
    logic [31:0] lacc_reg, lacc_next;
    logic [31:0] sacc_reg, sacc_next;
    logic [32:0] stot_reg, stot_next;
    logic [31:0] pstart_reg, pstart_next;
    logic        bad_reg, bad_next;
    logic        many_reg, many_next;

    logic [31:0] pos_inc;
    logic [32:0] stot_sum;
    logic [32:0] remain;
    logic [15:0] decl_full;
    logic [1:0]  bsel;
    logic [31:0] bword;
    logic [31:0] sacc_new;

    always_comb
    begin
        pos_inc   = (pos_reg == 32'hffff_ffff) ? pos_reg : pos_reg + 32'd1;
        decl_full = {data_byte, decl_reg[7:0]};
        bsel      = fcnt_reg[1:0];
        bword     = {24'd0, data_byte} << {bsel, 3'b000};
        sacc_new  = sacc_reg | bword;
        stot_sum  = stot_reg + {1'b0, sacc_new};
        if (stot_sum > ALL32 + 33'd1)
            stot_sum = ALL32 + 33'd1;
    end

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        fcnt_next   = fcnt_reg;
        decl_next   = decl_reg;
        cur_next    = cur_reg;
        nlen_next   = nlen_reg;
        noff_next   = noff_reg;
        flags_next  = flags_reg;
        lacc_next   = lacc_reg;
        sacc_next   = sacc_reg;
        stot_next   = stot_reg;
        pstart_next = pstart_reg;
        bad_next    = bad_reg;
        many_next   = many_reg;
        rec_valid   = 1'b0;
        rec_item    = '0;
        sum_valid   = 1'b0;
        sum_item    = '0;
        remain      = '0;
        if (in_valid)
        begin
            unique case (phase_reg)
                PH_MAGIC:
                begin
                    if (data_byte != sig_byte(pos_reg[2:0]))
                        bad_next = 1'b1;
                    if (pos_reg >= 32'(SIG_LEN - 1))
                        phase_next = (bad_next) ? PH_HALT : PH_DETECT;
                end
                PH_DETECT:
                begin
                    if (data_byte == BRACE_CHAR)
                        phase_next = PH_SEEK;
                    else
                    begin
                        decl_next  = {8'd0, data_byte};
                        phase_next = PH_COUNTHI;
                    end
                end
                PH_SEEK:
                begin
                    if (data_byte == NEWLINE_CHAR)
                    begin
                        pstart_next = pos_inc;
                        phase_next  = PH_BODY;
                    end
                end
                PH_COUNTHI:
                begin
                    decl_next = decl_full;
                    if (32'(decl_full) > 32'(MAX_ENTRIES))
                    begin
                        many_next  = 1'b1;
                        phase_next = PH_HALT;
                    end
                    else if (decl_full == 16'd0)
                    begin
                        pstart_next = pos_inc;
                        phase_next  = PH_BLOBS;
                    end
                    else
                        phase_next = PH_NAMELEN;
                end
                PH_NAMELEN:
                begin
                    nlen_next  = data_byte;
                    noff_next  = pos_inc;
                    fcnt_next  = '0;
                    phase_next = (data_byte != 8'd0) ? PH_NAME : PH_FLAGS;
                end
                PH_NAME:
                begin
                    fcnt_next = fcnt_reg + 8'd1;
                    if (fcnt_next >= nlen_reg)
                        phase_next = PH_FLAGS;
                end
                PH_FLAGS:
                begin
                    flags_next = data_byte;
                    fcnt_next  = '0;
                    lacc_next  = '0;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    lacc_next = lacc_reg | bword;
                    if (bsel == 2'd3)
                    begin
                        fcnt_next  = '0;
                        sacc_next  = '0;
                        phase_next = PH_STORED;
                    end
                    else
                        fcnt_next = fcnt_reg + 8'd1;
                end
                PH_STORED:
                begin
                    sacc_next = sacc_new;
                    if (bsel == 2'd3)
                    begin
                        rec_valid              = 1'b1;
                        rec_item.entry_index   = cur_reg[4:0];
                        rec_item.name_offset   = noff_reg;
                        rec_item.name_length   = nlen_reg;
                        rec_item.entry_flags   = flags_reg;
                        rec_item.plain_length  = lacc_reg;
                        rec_item.stored_length = sacc_new;
                        rec_item.blob_offset   = stot_reg[32] ? 32'hffff_ffff : stot_reg[31:0];
                        stot_next = stot_sum;
                        cur_next  = cur_reg + 6'd1;
                        fcnt_next = '0;
                        if (16'(cur_next) >= decl_reg)
                        begin
                            pstart_next = pos_inc;
                            phase_next  = PH_BLOBS;
                        end
                        else
                            phase_next = PH_NAMELEN;
                    end
                    else
                        fcnt_next = fcnt_reg + 8'd1;
                end
                PH_BODY, PH_BLOBS, PH_HALT: ;
                default: ;
            endcase
            pos_next = pos_inc;

            if (end_of_data)
            begin
                // bytes from the payload start up to and including this one
                remain = ({1'b0, pos_reg} + 33'd1) - {1'b0, pstart_next};
                if ({1'b0, pos_reg} + 33'd1 < {1'b0, pstart_next})
                    remain = '0;
                sum_valid            = 1'b1;
                sum_item.last        = 1'b1;
                sum_item.entry_count = cur_next;
                unique case (phase_next)
                    PH_MAGIC:   sum_item.status = ST_SHORT;
                    PH_DETECT:  sum_item.status = ST_EMPTY;
                    PH_SEEK:    sum_item.status = ST_NO_NL;
                    PH_COUNTHI: sum_item.status = ST_COUNT_CUT;
                    PH_BODY:
                    begin
                        sum_item.status         = ST_SINGLE_OK;
                        sum_item.payload_offset = pstart_next;
                        sum_item.payload_length = remain[32] ? 32'hffff_ffff
                                                             : remain[31:0];
                    end
                    PH_BLOBS:
                    begin
                        sum_item.payload_offset = pstart_next;
                        sum_item.payload_length = stot_next[32] ? 32'hffff_ffff
                                                                : stot_next[31:0];
                        if (stot_next[32] || (stot_next > remain))
                            sum_item.status = ST_BLOBS_CUT;
                        else
                            sum_item.status = ST_BUNDLE_OK;
                    end
                    PH_HALT:
                        sum_item.status = many_next ? ST_TOO_MANY : ST_BAD_MAGIC;
                    default: sum_item.status = ST_TOC_CUT;
                endcase
                phase_next  = PH_MAGIC;
                pos_next    = '0;
                fcnt_next   = '0;
                decl_next   = '0;
                cur_next    = '0;
                nlen_next   = '0;
                noff_next   = '0;
                flags_next  = '0;
                lacc_next   = '0;
                sacc_next   = '0;
                stot_next   = '0;
                pstart_next = '0;
                bad_next    = 1'b0;
                many_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_MAGIC;
            pos_reg    <= '0;
            fcnt_reg   <= '0;
            decl_reg   <= '0;
            cur_reg    <= '0;
            nlen_reg   <= '0;
            noff_reg   <= '0;
            flags_reg  <= '0;
            lacc_reg   <= '0;
            sacc_reg   <= '0;
            stot_reg   <= '0;
            pstart_reg <= '0;
            bad_reg    <= 1'b0;
            many_reg   <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            fcnt_reg   <= fcnt_next;
            decl_reg   <= decl_next;
            cur_reg    <= cur_next;
            nlen_reg   <= nlen_next;
            noff_reg   <= noff_next;
            flags_reg  <= flags_next;
            lacc_reg   <= lacc_next;
            sacc_reg   <= sacc_next;
            stot_reg   <= stot_next;
            pstart_reg <= pstart_next;
            bad_reg    <= bad_next;
            many_reg   <= many_next;
        end
    end
endmodule

// ===== rtl/core/ptsp_queue.sv =====
// result queue between parser and output; takes up to two items per cycle
// depends on ptsp_pkg
module ptsp_queue
    import ptsp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_a,
    input  result_t item_a,
    input  logic    wr_b,
    input  result_t item_b,
    output logic    almost_full,
    output logic    empty,
    input  logic    pop,
    output result_t head
);
    localparam int unsigned DEPTH = 8;
    localparam int unsigned AW = $clog2(DEPTH);

    result_t mem [DEPTH];
    logic [AW-1:0] rd_reg, rd_next, wr_reg, wr_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic          do_pop;
    logic [AW-1:0] wr_b_addr;

    always_comb
    begin
        do_pop    = pop && (cnt_reg != '0);
        wr_b_addr = wr_a ? wr_reg + AW'(1) : wr_reg;
        wr_next   = wr_reg + AW'(wr_a) + AW'(wr_b);
        rd_next   = rd_reg + AW'(do_pop);
        cnt_next  = cnt_reg + (AW+1)'(wr_a) + (AW+1)'(wr_b) - (AW+1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (wr_a)
            mem[wr_reg] <= item_a;
        if (wr_b)
            mem[wr_b_addr] <= item_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

    assign head        = mem[rd_reg];
    assign empty       = (cnt_reg == '0);
    assign almost_full = (cnt_reg > (AW+1)'(DEPTH - 2));
endmodule

// ===== rtl/core/package_toc_stream_parser.sv =====
// top level of the package toc stream parser
// depends on ptsp_pkg, ptsp_front, ptsp_queue, assert_macros.svh
//
// usage:
//   input channel: data_byte and end_of_data transfer when push is high and
//   full is low; one byte per cycle, back to back, until full rises.
//   result channel: the oldest result sits on the result ports while empty
//   is low; it transfers when pop is high.
//   a record result is queued in the cycle after its last stored-size byte;
//   the summary (last=1) follows the final byte the same way, so empty goes
//   low in the cycle after the input transfer.
//   throughput: one byte per cycle while full is low; up to two results per
//   byte are written into an eight-entry queue.
//   when the receiver stalls the queue fills; full rises while fewer than
//   two free slots remain, and the parser holds.
//   reset clears the parser to the magic phase and empties the queue.
//   after a summary the parser is back in its reset state for the next
//   package.
`include "assert_macros.svh"
module package_toc_stream_parser
    import ptsp_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = DEF_MAX_ENTRIES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        end_of_data,
    output logic        empty,
    input  logic        pop,
    output logic [4:0]  entry_index,
    output logic [31:0] name_offset,
    output logic [7:0]  name_length,
    output logic [7:0]  entry_flags,
    output logic [31:0] plain_length,
    output logic [31:0] stored_length,
    output logic [31:0] blob_offset,
    output logic [3:0]  status,
    output logic [5:0]  entry_count,
    output logic [31:0] payload_offset,
    output logic [31:0] payload_length,
    output logic        last
);
    logic    in_xfer;
    logic    rec_valid, sum_valid;
    result_t rec_item, sum_item, head;
    logic    wr_a, wr_b;
    result_t item_a;

    assign in_xfer = push && !full;

    ptsp_front #(.MAX_ENTRIES(MAX_ENTRIES)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_xfer),
        .data_byte  (data_byte),
        .end_of_data(end_of_data),
        .rec_valid  (rec_valid),
        .sum_valid  (sum_valid),
        .rec_item   (rec_item),
        .sum_item   (sum_item)
    );

    assign wr_a   = rec_valid || sum_valid;
    assign item_a = rec_valid ? rec_item : sum_item;
    assign wr_b   = rec_valid && sum_valid;

    ptsp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_a       (wr_a),
        .item_a     (item_a),
        .wr_b       (wr_b),
        .item_b     (sum_item),
        .almost_full(full),
        .empty      (empty),
        .pop        (pop),
        .head       (head)
    );

    assign entry_index    = head.entry_index;
    assign name_offset    = head.name_offset;
    assign name_length    = head.name_length;
    assign entry_flags    = head.entry_flags;
    assign plain_length   = head.plain_length;
    assign stored_length  = head.stored_length;
    assign blob_offset    = head.blob_offset;
    assign status         = head.status;
    assign entry_count    = head.entry_count;
    assign payload_offset = head.payload_offset;
    assign payload_length = head.payload_length;
    assign last           = head.last;

    `ASSERT_IMPLIES(a_sum_on_eod, clk, rst_n, in_xfer && end_of_data, sum_valid)
    `ASSERT_IMPLIES(a_no_sum_mid, clk, rst_n, sum_valid, in_xfer && end_of_data)
    `ASSERT_NEVER(a_rec_no_xfer, clk, rst_n, rec_valid && !in_xfer)
endmodule
